// ===== rtl/core/fbpa_pkg.sv =====
// Shared types, widths and codes for the fixed block pool allocator.
package fbpa_pkg;

    // Default sizing of the pool and of the address space.
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ADDR_BITS_DEF  = 32;

    // Field widths of the request, result and configuration registers.
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 21;
    localparam int CNT_W      = 9;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 6;
    localparam int M_TDATA_W  = 48;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = '0;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = BYTES_W'(1);
    localparam logic [CNT_W-1:0]   POOL_BLOCKS_RST = CNT_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLOCK_BYTES = 2'd1,
        CFG_POOL_BLOCKS = 2'd2
    } cfg_reg_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_EMPTY        = 2'd1,
        STAT_NOT_IN_POOL  = 2'd2,
        STAT_FULL_DROPPED = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_SUB,
        ST_DIV,
        ST_CHK,
        ST_FIN
    } fsm_t;

endpackage

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: LIFO free list with iterative address arithmetic.
//
// Hands out fixed-size blocks from a pool and takes them back. Each request on
// the slave stream is either an allocate (tuser 0) or a release (tuser 1, the
// address in tdata) and yields exactly one result on the master stream. Free
// block indices live on a LIFO stack held in a RAM; after reset, or after
// pool_blocks is written, entry i holds index i and every block is free (a
// bank of per-entry valid bits stands in for the reload, so there is no
// clearing pass). All address arithmetic runs through one shared 33-bit
// adder/subtractor under a small sequencer, one request at a time:
//   allocate: stack read, one shift-and-add multiply step per index bit,
//             then the base add and the output load.
//   release:  offset subtract, a restoring divider producing one quotient
//             bit per cycle, then the pool checks and the output load.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register so the next request can start while it waits.
// Configuration writes are taken at any time and are meant to be made only
// while no request is in flight.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ADDR_W-1:0]    s_axis_tdata,   // [31:0] release_address
    input  logic                 s_axis_tuser,   // [0] mode

    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] block_address, [40:32] blocks_free
    output logic [STAT_W-1:0]    m_axis_tuser,   // [1:0] status

    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int TOP_W = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W:0]   MASK_WIDE = ((ADDR_W+1)'(1) << AW) - (ADDR_W+1)'(1);
    localparam logic [ADDR_W-1:0] ADDR_MASK = MASK_WIDE[ADDR_W-1:0];

    // Clamp the block count register to 1 .. MAX_BLOCKS.
    function automatic logic [TOP_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [TOP_W-1:0] r;
        if (c == '0) begin
            r = TOP_W'(1);
        end else if (32'(c) > 32'(MAX_BLOCKS)) begin
            r = TOP_W'(MAX_BLOCKS);
        end else begin
            r = TOP_W'(c);
        end
        return r;
    endfunction

    // Configuration registers
    logic [ADDR_W-1:0]  pool_base_reg,   pool_base_next;
    logic [BYTES_W-1:0] block_bytes_reg, block_bytes_next;
    logic [CNT_W-1:0]   pool_blocks_reg, pool_blocks_next;

    // Sequencer and datapath registers
    fsm_t               state_reg,  state_next;
    logic [TOP_W-1:0]   top_reg,    top_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [ADDR_W-1:0]  addr_reg,   addr_next;   // release address, offset, then quotient
    logic [BYTES_W-1:0] rem_reg,    rem_next;
    logic [ADDR_W-1:0]  acc_reg,    acc_next;    // product, then final address
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [STEP_W-1:0]  step_reg,   step_next;
    stat_t              status_reg, status_next;
    logic [IDX_W-1:0]   rd_addr_reg, rd_addr_next;
    logic               vld_q_reg,  vld_q_next;

    // Output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [ADDR_W-1:0]  m_addr_reg,   m_addr_next;
    stat_t              m_status_reg, m_status_next;
    logic [CNT_W-1:0]   m_free_reg,   m_free_next;

    // Shared adder/subtractor
    logic [ADDR_W-1:0]  alu_a, alu_b, alu_b_eff;
    logic               alu_sub;
    logic [ADDR_W:0]    alu_sum;
    logic               alu_carry;

    // Stack RAM port signals
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [IDX_W-1:0]   ram_wdata, ram_rdata;

    logic [TOP_W-1:0]   count_eff;
    logic [BYTES_W-1:0] bytes_eff;
    logic [ADDR_W-1:0]  base_m;
    logic [BYTES_W:0]   rem_shift;
    logic               s_accept, cfg_accept, out_free;

    assign count_eff = eff_count(pool_blocks_reg);
    assign bytes_eff = (block_bytes_reg == '0) ? BYTES_W'(1) : block_bytes_reg;
    assign base_m    = pool_base_reg & ADDR_MASK;
    assign rem_shift = {rem_reg, addr_reg[ADDR_W-1]};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    // Pick the operands of the shared unit for the current step.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_SUB: begin
                alu_a   = addr_reg;
                alu_b   = base_m;
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = ADDR_W'(rem_shift);
                alu_b   = ADDR_W'(bytes_eff);
                alu_sub = 1'b1;
            end
            ST_MUL: begin
                alu_a = {acc_reg[ADDR_W-2:0], 1'b0};
                alu_b = idx_reg[IDX_W-1] ? ADDR_W'(bytes_eff) : '0;
            end
            ST_ADD: begin
                alu_a = acc_reg;
                alu_b = base_m;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b_eff} + (ADDR_W+1)'(alu_sub);
    assign alu_carry = alu_sum[ADDR_W];   // on subtract: a >= b

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            top_reg         <= eff_count(POOL_BLOCKS_RST);
            valid_reg       <= '0;
            pool_base_reg   <= POOL_BASE_RST;
            block_bytes_reg <= BLOCK_BYTES_RST;
            pool_blocks_reg <= POOL_BLOCKS_RST;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            top_reg         <= top_next;
            valid_reg       <= valid_next;
            pool_base_reg   <= pool_base_next;
            block_bytes_reg <= block_bytes_next;
            pool_blocks_reg <= pool_blocks_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        rd_addr_reg  <= rd_addr_next;
        vld_q_reg    <= vld_q_next;
        m_addr_reg   <= m_addr_next;
        m_status_reg <= m_status_next;
        m_free_reg   <= m_free_next;
    end

    // Sequencer: next state, datapath updates, stack access, config writes.
    always_comb begin
        state_next       = state_reg;
        top_next         = top_reg;
        valid_next       = valid_reg;
        addr_next        = addr_reg;
        rem_next         = rem_reg;
        acc_next         = acc_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        status_next      = status_reg;
        rd_addr_next     = rd_addr_reg;
        vld_q_next       = vld_q_reg;
        pool_base_next   = pool_base_reg;
        block_bytes_next = block_bytes_reg;
        pool_blocks_next = pool_blocks_reg;
        m_tvalid_next    = m_tvalid_reg && !m_axis_tready;
        m_addr_next      = m_addr_reg;
        m_status_next    = m_status_reg;
        m_free_next      = m_free_reg;
        ram_we           = 1'b0;
        ram_waddr        = IDX_W'(top_reg);
        ram_wdata        = IDX_W'(addr_reg);
        ram_re           = 1'b0;
        ram_raddr        = IDX_W'(top_reg - TOP_W'(1));

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    acc_next    = '0;
                    status_next = STAT_OK;
                    addr_next   = s_axis_tdata & ADDR_MASK;
                    if (!s_axis_tuser) begin
                        // Allocate: pop the top of the stack.
                        if (top_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            ram_re       = 1'b1;
                            rd_addr_next = ram_raddr;
                            vld_q_next   = valid_reg[ram_raddr];
                            top_next     = top_reg - TOP_W'(1);
                            state_next   = ST_RD;
                        end
                    end else if ((s_axis_tdata & ADDR_MASK) == '0) begin
                        status_next = STAT_NOT_IN_POOL;
                        state_next  = ST_FIN;
                    end else begin
                        state_next = ST_SUB;
                    end
                end
            end
            ST_RD: begin
                // An entry never pushed since reload still holds its own index.
                idx_next   = vld_q_reg ? ram_rdata : rd_addr_reg;
                step_next  = STEP_W'(IDX_W);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next  = alu_sum[ADDR_W-1:0];
                idx_next  = idx_reg << 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                acc_next   = alu_sum[ADDR_W-1:0] & ADDR_MASK;
                state_next = ST_FIN;
            end
            ST_SUB: begin
                if (!alu_carry) begin
                    status_next = STAT_NOT_IN_POOL;
                    state_next  = ST_FIN;
                end else begin
                    addr_next  = alu_sum[ADDR_W-1:0];
                    rem_next   = '0;
                    step_next  = STEP_W'(ADDR_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                addr_next = {addr_reg[ADDR_W-2:0], alu_carry};
                rem_next  = alu_carry ? alu_sum[BYTES_W-1:0] : rem_shift[BYTES_W-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (addr_reg >= ADDR_W'(count_eff)) begin
                    status_next = STAT_NOT_IN_POOL;
                end else if (top_reg >= count_eff) begin
                    status_next = STAT_FULL_DROPPED;
                end else begin
                    ram_we                = 1'b1;
                    valid_next[ram_waddr] = 1'b1;
                    top_next              = top_reg + TOP_W'(1);
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = acc_reg;
                    m_status_next = status_reg;
                    m_free_next   = CNT_W'(top_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_accept) begin
            case (cfg_index)
                CFG_POOL_BASE: begin
                    pool_base_next = cfg_data;
                end
                CFG_BLOCK_BYTES: begin
                    block_bytes_next = cfg_data[BYTES_W-1:0];
                end
                CFG_POOL_BLOCKS: begin
                    // Reload the free stack: every block free again.
                    pool_blocks_next = cfg_data[CNT_W-1:0];
                    top_next         = eff_count(cfg_data[CNT_W-1:0]);
                    valid_next       = '0;
                end
                default: begin
                    pool_base_next = pool_base_reg;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - ADDR_W - CNT_W)'(0), m_free_reg, m_addr_reg};
    assign m_axis_tuser  = m_status_reg;

    // The free count never runs past the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(top_reg) <= 32'(MAX_BLOCKS))
        else $error("free count beyond stack depth");

    // A push only lands below the configured block count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (top_reg < count_eff) && (state_reg == ST_CHK))
        else $error("stack push with no room");

    // The iteration counter is live for every multiply or divide step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_MUL) |-> (step_reg != '0))
        else $error("iteration counter exhausted mid-operation");

    // An empty report always comes with no free blocks and no address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg == STAT_EMPTY) |-> (m_free_reg == '0 && m_addr_reg == '0))
        else $error("empty status with free blocks or an address");

    // A result is loaded only out of the final step, which then goes idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("result not loaded on completion");

endmodule

// ===== rtl/core/fbpa_ram.sv =====
// Simple dual-port RAM, one write port and one registered read port.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/fbpa_checker.sv =====
// Checker for the block pool allocator: mirrors the free stack and compares every result.
module fbpa_checker
    import fbpa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [ADDR_W-1:0]    s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [STAT_W-1:0]    m_axis_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   granted_seen,
    output int                   empty_seen,
    output int                   rejected_seen,
    output int                   dropped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        stat_t             status;
        logic [CNT_W-1:0]  blocks_free;
    } pool_reply_t;

    logic [ADDR_W-1:0]  base_q;
    logic [BYTES_W-1:0] bytes_q;
    logic [CNT_W-1:0]   blocks_q;
    logic [7:0]         free_stack [MAX_BLOCKS_DEF];
    logic [CNT_W-1:0]   free_top;

    pool_reply_t predicted_replies [$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        granted_seen  = 0;
        empty_seen    = 0;
        rejected_seen = 0;
        dropped_seen  = 0;
    end

    function automatic logic [BYTES_W-1:0] unit_bytes();
        return (bytes_q == '0) ? BYTES_W'(1) : bytes_q;
    endfunction

    function automatic logic [CNT_W-1:0] live_blocks();
        if (blocks_q == '0)
            return CNT_W'(1);
        if (blocks_q > CNT_W'(MAX_BLOCKS_DEF))
            return CNT_W'(MAX_BLOCKS_DEF);
        return blocks_q;
    endfunction

    function automatic void reload_stack();
        for (int i = 0; i < MAX_BLOCKS_DEF; i++)
            free_stack[i] = 8'(i);
        free_top = live_blocks();
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        case (cfg_reg_t'(idx))
            CFG_POOL_BASE: base_q = val;
            CFG_BLOCK_BYTES: bytes_q = val[BYTES_W-1:0];
            CFG_POOL_BLOCKS: begin
                blocks_q = val[CNT_W-1:0];
                reload_stack();
            end
            default: ;
        endcase
    endfunction

    // Advance the mirrored pool by one request and return the reply it owes.
    function automatic pool_reply_t serve_request(logic rel, logic [ADDR_W-1:0] addr);
        pool_reply_t      r;
        logic [CNT_W-1:0] limit;
        logic [ADDR_W-1:0] slot;
        r.block_address = '0;
        r.status        = STAT_OK;
        limit           = live_blocks();
        if (!rel) begin
            if (free_top == '0) begin
                r.status = STAT_EMPTY;
            end else begin
                free_top = free_top - 1'b1;
                r.block_address = base_q
                    + ADDR_W'(free_stack[free_top[7:0]]) * ADDR_W'(unit_bytes());
            end
        end else if (addr == '0 || addr < base_q) begin
            r.status = STAT_NOT_IN_POOL;
        end else begin
            slot = (addr - base_q) / ADDR_W'(unit_bytes());
            if (slot >= ADDR_W'(limit)) begin
                r.status = STAT_NOT_IN_POOL;
            end else if (free_top >= limit) begin
                // Stack already holds every block: the release is flagged and dropped.
                r.status = STAT_FULL_DROPPED;
            end else begin
                free_stack[free_top[7:0]] = slot[7:0];
                free_top = free_top + 1'b1;
            end
        end
        r.blocks_free = free_top;
        return r;
    endfunction

    always @(posedge aclk) begin
        pool_reply_t want;
        pool_reply_t got;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            base_q   = POOL_BASE_RST;
            bytes_q  = BLOCK_BYTES_RST;
            blocks_q = POOL_BLOCKS_RST;
            reload_stack();
            predicted_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predicted_replies.push_back(serve_request(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got.block_address = m_axis_tdata[ADDR_W-1:0];
                got.blocks_free   = m_axis_tdata[ADDR_W+CNT_W-1:ADDR_W];
                got.status        = stat_t'(m_axis_tuser);
                if (predicted_replies.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, actual %h/%s/%0d",
                             $time, got.block_address, got.status.name(), got.blocks_free);
                    errs++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.block_address !== want.block_address) begin
                        $display("%0t: block_address expected %h, actual %h",
                                 $time, want.block_address, got.block_address);
                        errs++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %s, actual %s (%b)",
                                 $time, want.status.name(), got.status.name(), m_axis_tuser);
                        errs++;
                    end
                    if (got.blocks_free !== want.blocks_free) begin
                        $display("%0t: blocks_free expected %0d, actual %0d",
                                 $time, want.blocks_free, got.blocks_free);
                        errs++;
                    end
                    case (want.status)
                        STAT_OK: if (want.block_address != '0 || want.blocks_free == '0)
                            granted_seen <= granted_seen + 1;
                        STAT_EMPTY: empty_seen <= empty_seen + 1;
                        STAT_NOT_IN_POOL: rejected_seen <= rejected_seen + 1;
                        STAT_FULL_DROPPED: dropped_seen <= dropped_seen + 1;
                        default: ;
                    endcase
                end
                fail_count <= fail_count + errs;
            end
        end
        pending <= predicted_replies.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the block pool allocator: clock, reset, stimulus and verdict.
module tb_top
    import fbpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Settling time after the results drain, a little past the length of a release.
    localparam int SETTLE_CYCLES = 48;
    // Long receiver hold-off used to back the block up into its input.
    localparam int CHOKE_CYCLES  = 400;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 93;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ADDR_W-1:0]    s_axis_tdata  = '0;   // [31:0] release_address
    logic                 s_axis_tuser  = 1'b0; // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [31:0] block_address, [40:32] blocks_free
    logic [STAT_W-1:0]    m_axis_tuser;         // [1:0] status
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index     = CFG_POOL_BASE;
    logic [ADDR_W-1:0]    cfg_data      = '0;

    int fail_count, pending;
    int granted_seen, empty_seen, rejected_seen, dropped_seen;

    // Mirror of the last written settings, used only to aim releases at the pool.
    logic [ADDR_W-1:0] cur_base   = POOL_BASE_RST;
    int unsigned       cur_bytes  = 1;
    int unsigned       cur_blocks = 256;

    int send_calm     = 0;
    int choke_count   = 0;
    int requests_sent = 0;
    int settings_used = 1;

    fixed_block_pool_allocator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fbpa_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .granted_seen  (granted_seen),
        .empty_seen    (empty_seen),
        .rejected_seen (rejected_seen),
        .dropped_seen  (dropped_seen)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Pick an idle span: mostly none or short, a few long, with calm runs of no idling.
    function automatic int idle_span(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request from the stimulus.
    initial begin
        int calm;
        int stall;
        int choke_seen;
        calm       = 0;
        choke_seen = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (choke_seen != choke_count) begin
                choke_seen = choke_count;
                m_axis_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
            end else begin
                stall = idle_span(calm);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Offer one request; keep tvalid high across back-to-back requests.
    task automatic offer_request(input logic rel, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = idle_span(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        s_axis_tuser  <= rel;
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic grab();
        offer_request(1'b0, $urandom());
    endtask

    task automatic give_back(input logic [ADDR_W-1:0] addr);
        offer_request(1'b1, addr);
    endtask

    // Drop valid, wait for every result to drain, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write base and size, and the block count only when a reload is wanted.
    task automatic program_pool(input logic [ADDR_W-1:0] base, input int unsigned bytes,
                                input int unsigned blocks, input bit reload);
        write_register(CFG_POOL_BASE, base);
        write_register(CFG_BLOCK_BYTES, bytes);
        cur_base  = base;
        cur_bytes = bytes;
        if (reload) begin
            write_register(CFG_POOL_BLOCKS, blocks);
            cur_blocks = blocks;
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One random request aimed mostly inside the configured pool.
    task automatic random_request(input int grab_pct);
        int unsigned lim;
        int unsigned step;
        int unsigned r;
        logic [ADDR_W-1:0] addr;
        lim  = (cur_blocks == 0) ? 1 : ((cur_blocks > 256) ? 256 : cur_blocks);
        step = (cur_bytes == 0) ? 1 : cur_bytes;
        r    = $urandom_range(0, 99);
        if (r < grab_pct) begin
            grab();
        end else if (r < 86) begin
            addr = cur_base + $urandom_range(0, lim - 1) * step;
            if ($urandom_range(0, 1))
                addr = addr + $urandom_range(0, step - 1);
            give_back(addr);
        end else begin
            case ($urandom_range(0, 3))
                0: addr = '0;
                1: addr = cur_base - $urandom_range(1, 4096);
                2: addr = cur_base + lim * step + $urandom_range(0, 2 * step);
                default: addr = $urandom();
            endcase
            give_back(addr);
        end
    endtask

    // Pick settings for a random phase, leaning on small pools so empty and full both occur.
    task automatic random_settings();
        logic [ADDR_W-1:0] base;
        int unsigned bytes;
        int unsigned blocks;
        int unsigned r;
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = $urandom_range(1, 65535);
            2: base = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
            default: base = $urandom();
        endcase
        r = $urandom_range(0, 99);
        if (r < 15)      bytes = 0;
        else if (r < 55) bytes = $urandom_range(1, 64);
        else if (r < 85) bytes = $urandom_range(65, 4096);
        else             bytes = $urandom_range(4097, 1 << 20);
        r = $urandom_range(0, 99);
        if (r < 60)      blocks = $urandom_range(1, 16);
        else if (r < 80) blocks = $urandom_range(17, 256);
        else if (r < 90) blocks = 0;
        else             blocks = $urandom_range(257, 511);
        // Now and then rewrite base and size alone so the stack carries over.
        program_pool(base, bytes, blocks, ($urandom_range(0, 3) != 0));
    endtask

    initial begin
        int grab_pct;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: base 0, unit blocks, full pool of 256.
        grab();
        give_back(32'h0000_0000);     // zero address is never in the pool
        give_back(32'h0000_00FF);
        give_back(32'h0000_0005);     // every block free again: dropped
        give_back(32'h0000_0100);     // just past the pool
        give_back(32'hFFFF_FFFF);
        drain();

        // Zero size and zero count fall back to one byte and one block.
        program_pool(32'hFFFF_FF00, 0, 0, 1'b1);
        grab();
        grab();                       // pool empty
        give_back(32'hFFFF_FEFF);     // below base
        give_back(32'hFFFF_FF01);     // beyond the single block
        give_back(32'hFFFF_FF00);
        give_back(32'hFFFF_FF00);     // stack full again
        drain();

        // Size of 2^20 bytes, count above the maximum, address arithmetic wrapping past 2^32.
        program_pool(32'hFFF0_0000, 1 << 20, 300, 1'b1);
        grab();                       // address of the top index wraps around
        give_back(32'h0FE0_0000);     // the wrapped address lies below base
        give_back(32'hFFF0_3039);     // unaligned, floored to block 0
        grab();
        grab();
        grab();
        give_back(32'hFFF0_0000);     // double release goes through while there is room
        give_back(32'hFFF0_0000);
        grab();
        grab();
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_pool(32'h0000_0000, 1, 1, 1'b1);
                1: program_pool(32'hFFFF_FFFF, 1 << 20, 256, 1'b1);
                2: program_pool($urandom(), (1 << BYTES_W) - 1, 511, 1'b1);
                default: random_settings();
            endcase
            grab_pct = $urandom_range(30, 60);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off the receiver once, while requests keep coming.
                if (phase == 4 && n == 20)
                    choke_count++;
                random_request(grab_pct);
            end
            drain();
        end

        $display("Sent %0d requests over %0d pool settings, including one long output stall.",
                 requests_sent, settings_used);
        $display("Grants %0d, empty %0d, rejected addresses %0d, dropped releases %0d.",
                 granted_seen, empty_seen, rejected_seen, dropped_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fixed_block_pool_allocator.sv
tb/fbpa_checker.sv
tb/tb_top.sv
